// File: src/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants for the six-voice allocator with linear ADSR.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [1:0] KIND_TRIG   = 2'd0;
    localparam logic [1:0] KIND_REL    = 2'd1;
    localparam logic [1:0] KIND_CUT    = 2'd2;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ATTACK   = 3'd1;
    localparam logic [2:0] ST_DECAY    = 3'd2;
    localparam logic [2:0] ST_SUSTAIN  = 3'd3;
    localparam logic [2:0] ST_RELEASE  = 3'd4;

    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_BASE    = 3'd4;
    localparam logic [2:0] REG_DEPTH   = 3'd5;

    localparam logic [16:0] FULL       = 17'd65536;
    localparam logic [16:0] TIME_MAX   = 17'd131071;
    localparam logic [7:0]  FREE_SLOT  = 8'd255;
    localparam logic [12:0] SWEEP_HZ   = 13'd8000;
    localparam logic [14:0] CUT_MIN    = 15'd20;
    localparam logic [14:0] CUT_MAX    = 15'd20000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  note;
        logic [15:0] elapsed_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  voice;
        logic [6:0]  voice_note;
        logic [16:0] env_level;
        logic [14:0] cutoff_hz;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [15:0] attack_ms;
        logic [15:0] decay_ms;
        logic [16:0] sustain_level;
        logic [15:0] release_ms;
        logic [14:0] base_cutoff_hz;
        logic [16:0] env_depth;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic note_on;    // apply note on
        logic note_off;   // apply note off
        logic env_start;  // step envelope of current voice, start divide if needed
        logic env_finish; // write back envelope result
        logic mul1;       // depth * level
        logic mul2;       // * sweep, build cutoff, load output
        logic emit_alloc; // load trigger/release output
        logic next_voice; // advance voice index
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_on;
        logic op_off;
        logic op_tick;
        logic off_hit;
        logic div_busy;
        logic last_voice;
    } sts_t;

endpackage

// File: src/poly_voice_allocator_adsr.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_adsr
// Six-voice allocator with oldest-voice steal and a linear ADSR cutoff envelope.
// ----------------------------------------------------------------------------
// Note on, or note off that finds its voice: the trigger/release result is loaded
// into the output register once it is free. Tick: each voice steps through envelope
// start, divider wait, finish, two multiplies and output, sharing a single divider.
// Input ready only while the sequencer is idle; output holds until taken.
// Reset: all voices free and idle, registers at their default values.
module poly_voice_allocator_adsr #(
    parameter int VOICES = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pva_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pva_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [16:0]         cfg_data
);

    pva_pkg::cmd_t cmd;
    pva_pkg::sts_t sts;
    logic          out_last;

    pva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .out_last  (out_last)
    );

    pva_datapath #(.VOICES(VOICES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .out_last  (out_last),
        .sts       (sts),
        .out_word  (out_data)
    );

endmodule

// File: src/pva_div.sv
// ----------------------------------------------------------------------------
// pva_div
// Restoring divider, one quotient bit per cycle; 34-bit dividend, 17-bit divisor.
// ----------------------------------------------------------------------------
module pva_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] dividend,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic [16:0] quotient
);

    logic [33:0] q_reg, q_next;
    logic [17:0] r_reg, r_next;
    logic [16:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[16:0], q_reg[33]};
        diff      = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd34;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = diff;
                q_next = {q_reg[32:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg[16:0];

endmodule

// File: src/pva_datapath.sv
// ----------------------------------------------------------------------------
// pva_datapath
// Voice slots, envelope state, configuration registers and result assembly.
// ----------------------------------------------------------------------------
module pva_datapath #(
    parameter int VOICES = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pva_pkg::in_word_t in_word,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [16:0]       cfg_data,
    input  pva_pkg::cmd_t     cmd,
    input  logic              out_last,
    output pva_pkg::sts_t     sts,
    output pva_pkg::out_word_t out_word
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    pva_pkg::cfg_t     cfg_reg;
    pva_pkg::in_word_t in_reg;

    logic [7:0]  note_reg  [VOICES];
    logic [31:0] age_reg   [VOICES];
    logic [2:0]  stage_reg [VOICES];
    logic [16:0] time_reg  [VOICES];
    logic [16:0] level_reg [VOICES];
    logic [31:0] stamp_reg;

    logic [VW-1:0] vi_reg;
    logic [33:0]   prod_reg;
    logic [1:0]    alloc_kind_reg;
    logic [VW-1:0] alloc_v_reg;
    pva_pkg::out_word_t out_reg;

    // note lookup
    logic          hit_found, free_found;
    logic [VW-1:0] hit_v, free_v, old_v, on_v;

    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_v      = '0;
        free_v     = '0;
        old_v      = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (note_reg[i] == {1'b0, in_reg.note})
            begin
                hit_found = 1'b1;
                hit_v     = VW'(i);
            end
            if (note_reg[i] == pva_pkg::FREE_SLOT)
            begin
                free_found = 1'b1;
                free_v     = VW'(i);
            end
        end
        for (int i = 1; i < VOICES; i++)
            if (age_reg[i] < age_reg[old_v])
                old_v = VW'(i);
        on_v = hit_found ? hit_v : (free_found ? free_v : old_v);
    end

    // envelope step for current voice
    logic [16:0] s_used;
    logic [17:0] t_sum;
    logic [16:0] t_new;
    logic [2:0]  cur_stage;
    logic        need_div, done_stage;
    logic [33:0] div_num;
    logic [16:0] div_den;
    logic [16:0] imm_level;
    logic [2:0]  imm_stage;
    logic [16:0] imm_time;
    logic        div_start, div_busy;
    logic [16:0] div_q;

    always_comb
    begin
        s_used     = (cfg_reg.sustain_level > pva_pkg::FULL) ? pva_pkg::FULL
                                                              : cfg_reg.sustain_level;
        t_sum      = {1'b0, time_reg[vi_reg]} + {2'b0, in_reg.elapsed_ms};
        t_new      = t_sum[17] ? pva_pkg::TIME_MAX : t_sum[16:0];
        cur_stage  = stage_reg[vi_reg];
        need_div   = 1'b0;
        done_stage = 1'b0;
        div_num    = '0;
        div_den    = 17'd1;
        imm_level  = '0;
        imm_stage  = cur_stage;
        imm_time   = t_new;
        case (cur_stage)
            pva_pkg::ST_ATTACK:
            begin
                if (t_new >= {1'b0, cfg_reg.attack_ms})
                begin
                    imm_level = pva_pkg::FULL;
                    imm_stage = pva_pkg::ST_DECAY;
                    imm_time  = '0;
                end
                else
                begin
                    need_div = 1'b1;
                    div_num  = {1'b0, t_new, 16'd0};
                    div_den  = {1'b0, cfg_reg.attack_ms};
                end
            end
            pva_pkg::ST_DECAY:
            begin
                if (t_new >= {1'b0, cfg_reg.decay_ms})
                begin
                    imm_level = s_used;
                    imm_stage = pva_pkg::ST_SUSTAIN;
                end
                else
                begin
                    need_div = 1'b1;
                    div_num  = 34'(t_new * (pva_pkg::FULL - s_used));
                    div_den  = {1'b0, cfg_reg.decay_ms};
                end
            end
            pva_pkg::ST_SUSTAIN:
                imm_level = s_used;
            pva_pkg::ST_RELEASE:
            begin
                if (t_new >= {1'b0, cfg_reg.release_ms})
                begin
                    imm_level = '0;
                    imm_stage = pva_pkg::ST_IDLE;
                end
                else
                begin
                    need_div = 1'b1;
                    div_num  = 34'(s_used * ({1'b0, cfg_reg.release_ms} - t_new));
                    div_den  = {1'b0, cfg_reg.release_ms};
                end
            end
            default:
            begin
                imm_stage = pva_pkg::ST_IDLE;
                imm_level = '0;
            end
        endcase
        done_stage = ~need_div;
    end

    assign div_start = cmd.env_start & need_div;

    pva_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    logic        pend_div_reg;
    logic [16:0] pend_level_reg;
    logic [16:0] fin_level;
    logic [46:0] mod_full;
    logic [15:0] mod_hz;
    logic [15:0] cut_sum;
    logic [14:0] cut_clamped;

    always_comb
    begin
        fin_level = pend_level_reg;
        if (pend_div_reg)
        begin
            case (cur_stage)
                pva_pkg::ST_DECAY:
                    fin_level = pva_pkg::FULL - div_q;
                default:
                    fin_level = div_q;
            endcase
        end
        mod_full    = prod_reg * pva_pkg::SWEEP_HZ;
        mod_hz      = {1'b0, mod_full[46:32]};
        cut_sum     = {1'b0, cfg_reg.base_cutoff_hz} + mod_hz;
        cut_clamped = (cut_sum < {1'b0, pva_pkg::CUT_MIN}) ? pva_pkg::CUT_MIN :
                      (cut_sum > {1'b0, pva_pkg::CUT_MAX}) ? pva_pkg::CUT_MAX :
                      cut_sum[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_ms      <= 16'd10;
            cfg_reg.decay_ms       <= 16'd300;
            cfg_reg.sustain_level  <= 17'd45875;
            cfg_reg.release_ms     <= 16'd500;
            cfg_reg.base_cutoff_hz <= 15'd1200;
            cfg_reg.env_depth      <= 17'd32768;
            for (int i = 0; i < VOICES; i++)
            begin
                note_reg[i]  <= pva_pkg::FREE_SLOT;
                age_reg[i]   <= '0;
                stage_reg[i] <= pva_pkg::ST_IDLE;
                time_reg[i]  <= '0;
                level_reg[i] <= '0;
            end
            stamp_reg      <= '0;
            vi_reg         <= '0;
            pend_div_reg   <= 1'b0;
            pend_level_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pva_pkg::REG_ATTACK:  cfg_reg.attack_ms      <= cfg_data[15:0];
                    pva_pkg::REG_DECAY:   cfg_reg.decay_ms       <= cfg_data[15:0];
                    pva_pkg::REG_SUSTAIN: cfg_reg.sustain_level  <= cfg_data;
                    pva_pkg::REG_RELEASE: cfg_reg.release_ms     <= cfg_data[15:0];
                    pva_pkg::REG_BASE:    cfg_reg.base_cutoff_hz <= cfg_data[14:0];
                    pva_pkg::REG_DEPTH:   cfg_reg.env_depth      <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
                vi_reg <= '0;
            if (cmd.note_on)
            begin
                stage_reg[on_v] <= pva_pkg::ST_ATTACK;
                time_reg[on_v]  <= '0;
                level_reg[on_v] <= '0;
                note_reg[on_v]  <= {1'b0, in_reg.note};
                stamp_reg       <= stamp_reg + 32'd1;
                age_reg[on_v]   <= stamp_reg + 32'd1;
            end
            if (cmd.note_off)
            begin
                stage_reg[hit_v] <= pva_pkg::ST_RELEASE;
                time_reg[hit_v]  <= '0;
                note_reg[hit_v]  <= pva_pkg::FREE_SLOT;
            end
            if (cmd.env_start)
            begin
                pend_div_reg   <= need_div;
                pend_level_reg <= imm_level;
                time_reg[vi_reg] <= imm_time;
                if (done_stage)
                    stage_reg[vi_reg] <= imm_stage;
            end
            if (cmd.env_finish)
                level_reg[vi_reg] <= fin_level;
            if (cmd.next_voice)
                vi_reg <= vi_reg + VW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_word;
        if (cmd.note_on)
        begin
            alloc_kind_reg <= pva_pkg::KIND_TRIG;
            alloc_v_reg    <= on_v;
        end
        if (cmd.note_off)
        begin
            alloc_kind_reg <= pva_pkg::KIND_REL;
            alloc_v_reg    <= hit_v;
        end
        if (cmd.mul1)
            prod_reg <= cfg_reg.env_depth * level_reg[vi_reg];
        if (cmd.mul2)
        begin
            out_reg.kind       <= pva_pkg::KIND_CUT;
            out_reg.voice      <= 3'(vi_reg);
            out_reg.voice_note <= (note_reg[vi_reg] == pva_pkg::FREE_SLOT) ? 7'd0
                                                            : note_reg[vi_reg][6:0];
            out_reg.env_level  <= level_reg[vi_reg];
            out_reg.cutoff_hz  <= cut_clamped;
            out_reg.last       <= out_last;
        end
        if (cmd.emit_alloc)
        begin
            out_reg.kind       <= alloc_kind_reg;
            out_reg.voice      <= 3'(alloc_v_reg);
            out_reg.voice_note <= in_reg.note;
            out_reg.env_level  <= '0;
            out_reg.cutoff_hz  <= '0;
            out_reg.last       <= 1'b1;
        end
    end

    assign sts.op_on      = in_reg.operation == pva_pkg::OP_NOTE_ON;
    assign sts.op_off     = in_reg.operation == pva_pkg::OP_NOTE_OFF;
    assign sts.op_tick    = (in_reg.operation == pva_pkg::OP_TICK) &&
                            (in_reg.elapsed_ms != 16'd0);
    assign sts.off_hit    = hit_found;
    assign sts.div_busy   = div_busy;
    assign sts.last_voice = vi_reg == VW'(VOICES - 1);
    assign out_word       = out_reg;

endmodule

// File: src/pva_ctrl.sv
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer: decodes the word, walks voices on a tick, drives the output stage.
// ----------------------------------------------------------------------------
module pva_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  pva_pkg::sts_t sts,
    output pva_pkg::cmd_t cmd,
    output logic          out_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ENV, S_WAIT, S_FIN, S_MUL1, S_MUL2, S_OUT, S_AOUT
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        out_last    = sts.last_voice;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            S_DECODE:
            begin
                if (sts.op_on)
                begin
                    cmd.note_on = 1'b1;
                    state_next  = S_AOUT;
                end
                else if (sts.op_off && sts.off_hit)
                begin
                    cmd.note_off = 1'b1;
                    state_next   = S_AOUT;
                end
                else if (sts.op_tick)
                    state_next = S_ENV;
                else
                    state_next = S_IDLE;
            end
            S_AOUT:
                if (!ovalid_reg)
                begin
                    cmd.emit_alloc = 1'b1;
                    ovalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            S_ENV:
            begin
                cmd.env_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
                if (!sts.div_busy)
                    state_next = S_FIN;
            S_FIN:
            begin
                cmd.env_finish = 1'b1;
                state_next     = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
                if (!ovalid_reg)
                begin
                    cmd.mul2    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
            S_OUT:
            begin
                if (sts.last_voice)
                    state_next = S_IDLE;
                else
                begin
                    cmd.next_voice = 1'b1;
                    state_next     = S_ENV;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ovalid_reg;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul2 || cmd.emit_alloc) |-> !ovalid_reg)
        else $error("output overwritten");
    a_fin_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.env_finish |-> !sts.div_busy)
        else $error("finish while dividing");
`endif

endmodule
